[src/assert_macros.svh]
// Assertion macros shared by the lane-change decision RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lcd_pkg.sv]
// Types, codes and reset values for the lane-change decision block.
package lcd_pkg;

    typedef enum logic [1:0]
    {
        KIND_FRAME  = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_DECIDE = 2'd2
    } kind_t;

    typedef enum logic [1:0]
    {
        MOVE_KEEP  = 2'd0,
        MOVE_RIGHT = 2'd1,
        MOVE_LEFT  = 2'd2
    } move_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SAFE_GAP    = 2'd0;
    localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
    localparam logic [1:0] REG_SPEED_STEP  = 2'd2;
    localparam logic [1:0] REG_LAST_LANE   = 2'd3;

    localparam logic [15:0] SAFE_GAP_RST    = 16'd480;
    localparam logic [15:0] SPEED_LIMIT_RST = 16'd12672;
    localparam logic [11:0] SPEED_STEP_RST  = 12'd57;
    localparam logic [1:0]  LAST_LANE_RST   = 2'd2;

    // 10000 m in 1/16 m units.
    localparam logic [17:0] FAR_GAP = 18'd160000;

    // Tracker slots: left neighbour, own lane, right neighbour.
    localparam int unsigned SIDE_LEFT  = 0;
    localparam int unsigned SIDE_OWN   = 1;
    localparam int unsigned SIDE_RIGHT = 2;

    typedef struct packed
    {
        logic [15:0] safe_gap;
        logic [15:0] speed_limit;
        logic [11:0] speed_step;
        logic [1:0]  last_lane;
    } cfg_t;

    typedef struct packed
    {
        logic [1:0]  kind;
        logic [1:0]  lane_index;
        logic [17:0] position;
        logic [15:0] car_speed;
        logic [15:0] ref_speed;
    } item_t;

    typedef struct packed
    {
        logic [1:0]       ego_lane;
        logic [2:0]       blocked;
        logic [2:0][15:0] near_speed;
    } track_t;

    typedef struct packed
    {
        logic [1:0]  new_lane;
        logic [15:0] new_ref_speed;
        move_t       move;
    } decision_t;

endpackage

[src/lcd_cfg_regs.sv]
// Configuration registers behind the APB-style port.
module lcd_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output lcd_pkg::cfg_t      cfg
);

    lcd_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.safe_gap    <= lcd_pkg::SAFE_GAP_RST;
            cfg_reg.speed_limit <= lcd_pkg::SPEED_LIMIT_RST;
            cfg_reg.speed_step  <= lcd_pkg::SPEED_STEP_RST;
            cfg_reg.last_lane   <= lcd_pkg::LAST_LANE_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                lcd_pkg::REG_SAFE_GAP:    cfg_reg.safe_gap    <= pwdata[15:0];
                lcd_pkg::REG_SPEED_LIMIT: cfg_reg.speed_limit <= pwdata[15:0];
                lcd_pkg::REG_SPEED_STEP:  cfg_reg.speed_step  <= pwdata[11:0];
                lcd_pkg::REG_LAST_LANE:   cfg_reg.last_lane   <= pwdata[1:0];
                default:                  cfg_reg.last_lane   <= cfg_reg.last_lane;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lcd_pkg::REG_SAFE_GAP:    prdata = {16'd0, cfg_reg.safe_gap};
            lcd_pkg::REG_SPEED_LIMIT: prdata = {16'd0, cfg_reg.speed_limit};
            lcd_pkg::REG_SPEED_STEP:  prdata = {20'd0, cfg_reg.speed_step};
            lcd_pkg::REG_LAST_LANE:   prdata = {30'd0, cfg_reg.last_lane};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

[src/lcd_tracker.sv]
// Ego position and per-lane trackers, updated by frame, report and decide words.
module lcd_tracker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  lcd_pkg::item_t       item,
    input  lcd_pkg::cfg_t        cfg,
    input  logic [1:0]           new_lane,
    output lcd_pkg::track_t      track
);

    logic [1:0]       ego_lane_reg;
    logic [17:0]      ego_pos_reg;
    logic [2:0]       blocked_reg;
    logic [2:0][17:0] gap_reg;
    logic [2:0][15:0] speed_reg;

    logic signed [18:0] rel_pos;
    logic signed [18:0] gap_pos;
    logic signed [18:0] gap_neg;
    logic               ahead;
    logic               in_front_gap;
    logic               in_side_gap;
    logic [2:0]         hit;
    logic [2:0]         blk_set;
    logic [2:0]         near_set;

    assign rel_pos = signed'({1'b0, item.position}) - signed'({1'b0, ego_pos_reg});
    assign gap_pos = signed'({3'b000, cfg.safe_gap});
    assign gap_neg = -gap_pos;

    assign ahead        = (rel_pos > 19'sd0);
    assign in_front_gap = ahead && (rel_pos < gap_pos);
    assign in_side_gap  = (rel_pos < gap_pos) && (rel_pos > gap_neg);

    always_comb
    begin
        hit = 3'b000;
        // Own lane takes precedence; the neighbours only exist inside lanes 0 to 3.
        if (item.lane_index == ego_lane_reg)
        begin
            hit[lcd_pkg::SIDE_OWN] = 1'b1;
        end
        else if ((ego_lane_reg != 2'd0) && (item.lane_index == ego_lane_reg - 2'd1))
        begin
            hit[lcd_pkg::SIDE_LEFT] = 1'b1;
        end
        else if ((ego_lane_reg != 2'd3) && (item.lane_index == ego_lane_reg + 2'd1))
        begin
            hit[lcd_pkg::SIDE_RIGHT] = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (i == lcd_pkg::SIDE_OWN)
            begin
                blk_set[i] = hit[i] && in_front_gap;
            end
            else
            begin
                blk_set[i] = hit[i] && in_side_gap;
            end
            near_set[i] = hit[i] && ahead && (rel_pos[17:0] < gap_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ego_lane_reg <= 2'd0;
            ego_pos_reg  <= 18'd0;
            blocked_reg  <= 3'b000;
            for (int i = 0; i < 3; i++)
            begin
                gap_reg[i]   <= lcd_pkg::FAR_GAP;
                speed_reg[i] <= 16'd0;
            end
        end
        else if (fire)
        begin
            case (item.kind)
                lcd_pkg::KIND_FRAME:
                begin
                    ego_lane_reg <= item.lane_index;
                    ego_pos_reg  <= item.position;
                    blocked_reg  <= 3'b000;
                    for (int i = 0; i < 3; i++)
                    begin
                        gap_reg[i]   <= lcd_pkg::FAR_GAP;
                        speed_reg[i] <= 16'd0;
                    end
                end
                lcd_pkg::KIND_REPORT:
                begin
                    blocked_reg <= blocked_reg | blk_set;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (near_set[i])
                        begin
                            gap_reg[i]   <= rel_pos[17:0];
                            speed_reg[i] <= item.car_speed;
                        end
                    end
                end
                lcd_pkg::KIND_DECIDE:
                begin
                    ego_lane_reg <= new_lane;
                end
                default:
                begin
                    ego_lane_reg <= ego_lane_reg;
                end
            endcase
        end
    end

    assign track.ego_lane   = ego_lane_reg;
    assign track.blocked    = blocked_reg;
    assign track.near_speed = speed_reg;

endmodule

[src/lcd_decide.sv]
// Lane choice by least cost and reference speed update for a decide word.
module lcd_decide
(
    input  lcd_pkg::track_t    track,
    input  lcd_pkg::cfg_t      cfg,
    input  logic [15:0]        ref_speed,
    output lcd_pkg::decision_t dec
);

    logic        own_blk;
    logic        right_ok;
    logic        left_ok;
    logic [15:0] spd_r;
    logic [15:0] spd_l;
    logic        take_r;
    logic        take_l;
    logic [16:0] keep_raw;
    logic [15:0] keep_spd;

    assign own_blk = track.blocked[lcd_pkg::SIDE_OWN];
    assign spd_r   = track.near_speed[lcd_pkg::SIDE_RIGHT];
    assign spd_l   = track.near_speed[lcd_pkg::SIDE_LEFT];

    // A change costs the limit less the lane speed; it beats keeping the lane
    // only when that speed is non-zero, and the faster lane wins, right on a tie.
    assign right_ok = own_blk && !track.blocked[lcd_pkg::SIDE_RIGHT]
                      && (track.ego_lane < cfg.last_lane) && (spd_r != 16'd0);
    assign left_ok  = own_blk && !track.blocked[lcd_pkg::SIDE_LEFT]
                      && (track.ego_lane != 2'd0) && (spd_l != 16'd0);

    assign take_r = right_ok && (!left_ok || (spd_r >= spd_l));
    assign take_l = left_ok && !take_r;

    always_comb
    begin
        if (own_blk)
        begin
            keep_raw = (ref_speed > {4'd0, cfg.speed_step})
                       ? {1'b0, ref_speed - {4'd0, cfg.speed_step}} : 17'd0;
        end
        else if (ref_speed < cfg.speed_limit)
        begin
            keep_raw = {1'b0, ref_speed} + {5'd0, cfg.speed_step};
        end
        else
        begin
            keep_raw = {1'b0, ref_speed};
        end
        keep_spd = (keep_raw > {1'b0, cfg.speed_limit}) ? cfg.speed_limit : keep_raw[15:0];
    end

    always_comb
    begin
        if (take_r)
        begin
            dec.move          = lcd_pkg::MOVE_RIGHT;
            dec.new_lane      = track.ego_lane + 2'd1;
            dec.new_ref_speed = ref_speed;
        end
        else if (take_l)
        begin
            dec.move          = lcd_pkg::MOVE_LEFT;
            dec.new_lane      = track.ego_lane - 2'd1;
            dec.new_ref_speed = ref_speed;
        end
        else
        begin
            dec.move          = lcd_pkg::MOVE_KEEP;
            dec.new_lane      = track.ego_lane;
            dec.new_ref_speed = keep_spd;
        end
    end

endmodule

[src/lane_change_decision.sv]
// Top level of the highway lane-change decider: input register, trackers, result register.
// The result of a decide word is registered when the word leaves the input register.
// Throughput: one word per cycle; a decide word waits in the input register only while
// the previous result is still held in the result register by a low m_axis_tready.
// Reset: rst_n clears the trackers, ego lane and position and both valid flags, and loads
// the configuration registers with their reset values.
`include "assert_macros.svh"

module lane_change_decision
(
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] lane_index, [19:2] position, [35:20] car_speed, [51:36] ref_speed, rest zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    // Result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] new_lane, [17:2] new_ref_speed, [19:18] move, rest zero
    output logic [23:0] m_axis_tdata
);

    lcd_pkg::cfg_t      cfg;
    lcd_pkg::track_t    track;
    lcd_pkg::decision_t dec;

    logic               in_valid_reg;
    lcd_pkg::item_t     in_item_reg;
    logic               in_fire;
    logic               is_decide;
    logic               out_valid_reg;
    lcd_pkg::decision_t out_dec_reg;

    assign pready = 1'b1;

    lcd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign is_decide     = (in_item_reg.kind == lcd_pkg::KIND_DECIDE);
    // A decide word may only leave the input register if the result slot is free.
    assign in_fire       = in_valid_reg && (!is_decide || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind       <= s_axis_tuser;
            in_item_reg.lane_index <= s_axis_tdata[1:0];
            in_item_reg.position   <= s_axis_tdata[19:2];
            in_item_reg.car_speed  <= s_axis_tdata[35:20];
            in_item_reg.ref_speed  <= s_axis_tdata[51:36];
        end
    end

    lcd_tracker u_tracker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (in_fire),
        .item     (in_item_reg),
        .cfg      (cfg),
        .new_lane (dec.new_lane),
        .track    (track)
    );

    lcd_decide u_decide
    (
        .track     (track),
        .cfg       (cfg),
        .ref_speed (in_item_reg.ref_speed),
        .dec       (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && is_decide)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && is_decide)
        begin
            out_dec_reg <= dec;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_dec_reg.move, out_dec_reg.new_ref_speed,
                            out_dec_reg.new_lane};

    `ASSERT_NEXT(a_decide_gives_result, clk, rst_n, in_fire && is_decide, m_axis_tvalid, "decide word produced no result")
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, in_valid_reg && is_decide && m_axis_tvalid && !m_axis_tready, !in_fire, "pending result would be overwritten")
    `ASSERT_NEXT(a_keep_holds_lane, clk, rst_n, in_fire && is_decide && (dec.move == lcd_pkg::MOVE_KEEP), $stable(track.ego_lane), "keep decision changed the ego lane")
    `ASSERT_IMPLIES(a_keep_speed_clamped, clk, rst_n, in_fire && is_decide && (dec.move == lcd_pkg::MOVE_KEEP), dec.new_ref_speed <= cfg.speed_limit, "kept reference speed above limit")

endmodule

[tb/sv/lane_change_decision_tb.sv]
// Self-checking testbench for the lane-change decider: directed table, random traffic, APB setup.
module lane_change_decision_tb;
    import lcd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 6;
    localparam int POS_MAX = 262143;

    typedef struct
    {
        item_t     w;
        bit        fixed_exp;
        decision_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    // Predicted state of the decider.
    cfg_t        cfg_est;
    logic [1:0]  ego_lane_est;
    logic [17:0] ego_pos_est;
    bit          blocked_est[3];
    int          near_gap_est[3];
    int          near_speed_est[3];

    decision_t   decisions_due[$];
    dir_row_t    dir_rows[$];

    int mismatches = 0;
    int words_sent = 0;
    int decisions_seen = 0;
    int settings_used = 1;
    int move_count[3] = '{0, 0, 0};
    int quiet_cycles = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit hold_req = 1'b0;

    lane_change_decision uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void clear_trackers_est();
        for (int i = 0; i < 3; i++)
        begin
            blocked_est[i] = 1'b0;
            near_gap_est[i] = int'(FAR_GAP);
            near_speed_est[i] = 0;
        end
    endfunction

    // Cost is the limit minus the lane speed; anything that forbids the change costs the full limit.
    function automatic int change_cost(input int side, input bit at_edge);
        if (at_edge || blocked_est[side] || !blocked_est[SIDE_OWN])
            return int'(cfg_est.speed_limit);
        return int'(cfg_est.speed_limit) - near_speed_est[side];
    endfunction

    // Advances the predicted state by one word; returns 1 when a decision word is due.
    function automatic bit decide_or_track(input item_t w, output decision_t res);
        int d, g, el, ln, side, lim, v;
        int c_keep, c_right, c_left, c_min;
        res = '0;
        el = int'(ego_lane_est);
        ln = int'(w.lane_index);
        lim = int'(cfg_est.speed_limit);
        if (w.kind == KIND_FRAME)
        begin
            ego_lane_est = w.lane_index;
            ego_pos_est = w.position;
            clear_trackers_est();
            return 1'b0;
        end
        if (w.kind == KIND_REPORT)
        begin
            d = int'(w.position) - int'(ego_pos_est);
            g = int'(cfg_est.safe_gap);
            if (ln == el)
            begin
                side = SIDE_OWN;
                if (d > 0 && d < g)
                    blocked_est[side] = 1'b1;
            end
            else if (el > 0 && ln == el - 1)
            begin
                side = SIDE_LEFT;
                if (d < g && d > -g)
                    blocked_est[side] = 1'b1;
            end
            else if (ln == el + 1)
            begin
                side = SIDE_RIGHT;
                if (d < g && d > -g)
                    blocked_est[side] = 1'b1;
            end
            else
                return 1'b0;
            if (d > 0 && d < near_gap_est[side])
            begin
                near_gap_est[side] = d;
                near_speed_est[side] = int'(w.car_speed);
            end
            return 1'b0;
        end
        if (w.kind != KIND_DECIDE)
            return 1'b0;
        c_keep = lim;
        c_right = change_cost(SIDE_RIGHT, ego_lane_est >= cfg_est.last_lane);
        c_left = change_cost(SIDE_LEFT, ego_lane_est == 2'd0);
        c_min = c_keep;
        if (c_right < c_min)
            c_min = c_right;
        if (c_left < c_min)
            c_min = c_left;
        v = int'(w.ref_speed);
        if (c_keep == c_min)
        begin
            res.move = MOVE_KEEP;
            if (blocked_est[SIDE_OWN])
                v = (v > int'(cfg_est.speed_step)) ? v - int'(cfg_est.speed_step) : 0;
            else if (v < lim)
                v = v + int'(cfg_est.speed_step);
            if (v > lim)
                v = lim;
        end
        else if (c_right == c_min)
        begin
            res.move = MOVE_RIGHT;
            ego_lane_est = ego_lane_est + 2'd1;
        end
        else
        begin
            res.move = MOVE_LEFT;
            ego_lane_est = ego_lane_est - 2'd1;
        end
        res.new_lane = ego_lane_est;
        res.new_ref_speed = v[15:0];
        return 1'b1;
    endfunction

    task automatic send_word(input item_t w, input bit fixed_exp, input decision_t want);
        int gap;
        decision_t res;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= w.kind;
        s_axis_tdata <= {4'd0, w.ref_speed, w.car_speed, w.position, w.lane_index};
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        if (decide_or_track(w, res))
            decisions_due.push_back(fixed_exp ? want : res);
    endtask

    // Lets every outstanding decision come back and the pipeline empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (decisions_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] back;
        mask = 32'hFFFF;
        case (idx)
            REG_SAFE_GAP:    cfg_est.safe_gap = val[15:0];
            REG_SPEED_LIMIT: cfg_est.speed_limit = val[15:0];
            REG_SPEED_STEP:
            begin
                mask = 32'hFFF;
                cfg_est.speed_step = val[11:0];
            end
            REG_LAST_LANE:
            begin
                mask = 32'h3;
                cfg_est.last_lane = val[1:0];
            end
            default:
            begin
                mask = 32'hFFFF;
            end
        endcase
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        back = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (back !== (val & mask))
        begin
            $error("register %0d read back: expected %0h, actual %0h", idx, val & mask, back);
            mismatches++;
        end
    endtask

    task automatic set_config(input int gap, input int lim, input int step, input int last);
        drain();
        set_reg(REG_SAFE_GAP, 32'(gap));
        set_reg(REG_SPEED_LIMIT, 32'(lim));
        set_reg(REG_SPEED_STEP, 32'(step));
        set_reg(REG_LAST_LANE, 32'(last));
        settings_used++;
    endtask

    task automatic add_row(input kind_t k, input int lane, input int pos, input int cspd,
                           input int rspd, input bit fixed_exp, input int exp_lane,
                           input int exp_speed, input move_t exp_move);
        dir_row_t row;
        row.w.kind = k;
        row.w.lane_index = 2'(lane);
        row.w.position = 18'(pos);
        row.w.car_speed = 16'(cspd);
        row.w.ref_speed = 16'(rspd);
        row.fixed_exp = fixed_exp;
        row.want.new_lane = 2'(exp_lane);
        row.want.new_ref_speed = 16'(exp_speed);
        row.want.move = exp_move;
        dir_rows.push_back(row);
    endtask

    // Mostly well-formed frames (start, reports near the ego car, decides), some noise words.
    task automatic run_traffic(input int n_words, input bit steady);
        int start, el, p, q, off, span, nrep, ndec, r, lim, delta;
        item_t w;
        decision_t none;
        none = '0;
        start = words_sent;
        lim = int'(cfg_est.speed_limit);
        while (words_sent - start < n_words)
        begin
            if (!steady && $urandom_range(0, 9) == 0)
                tx_calm = !tx_calm;
            if ($urandom_range(0, 9) == 0)
            begin
                w.kind = 2'($urandom_range(0, 3));
                w.lane_index = 2'($urandom_range(0, 3));
                w.position = 18'($urandom_range(0, POS_MAX));
                w.car_speed = 16'($urandom_range(0, 65535));
                w.ref_speed = 16'($urandom_range(0, 65535));
                send_word(w, 1'b0, none);
            end
            else
            begin
                el = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, int'(cfg_est.last_lane));
                r = $urandom_range(0, 9);
                p = (r == 0) ? 0 : (r == 1) ? POS_MAX : $urandom_range(0, POS_MAX);
                w.kind = KIND_FRAME;
                w.lane_index = 2'(el);
                w.position = 18'(p);
                w.car_speed = 16'($urandom_range(0, 65535));
                w.ref_speed = 16'($urandom_range(0, 65535));
                send_word(w, 1'b0, none);
                nrep = $urandom_range(0, 6);
                for (int i = 0; i < nrep; i++)
                begin
                    r = $urandom_range(0, 3);
                    delta = (r == 0) ? 0 : (r == 1) ? -1 : (r == 2) ? 1 : $urandom_range(0, 3);
                    span = int'(cfg_est.safe_gap) + 32;
                    if ($urandom_range(0, 3) != 0)
                        off = int'($urandom_range(0, 2 * span)) - span;
                    else
                        off = int'($urandom_range(0, POS_MAX)) - p;
                    q = p + off;
                    if (q < 0)
                        q = 0;
                    if (q > POS_MAX)
                        q = POS_MAX;
                    w.kind = KIND_REPORT;
                    w.lane_index = 2'(el + delta);
                    w.position = 18'(q);
                    w.car_speed = $urandom_range(0, 1) ? 16'($urandom_range(0, lim))
                                                      : 16'($urandom_range(0, 65535));
                    send_word(w, 1'b0, none);
                end
                ndec = $urandom_range(1, 2);
                for (int i = 0; i < ndec; i++)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        q = 0;
                    else if (r == 1)
                        q = 65535;
                    else if (r < 6)
                        q = lim + $urandom_range(0, 32) - 16;
                    else
                        q = $urandom_range(0, 65535);
                    if (q < 0)
                        q = 0;
                    if (q > 65535)
                        q = 65535;
                    w.kind = KIND_DECIDE;
                    w.lane_index = 2'($urandom_range(0, 3));
                    w.position = 18'($urandom_range(0, POS_MAX));
                    w.car_speed = 16'($urandom_range(0, 65535));
                    w.ref_speed = 16'(q);
                    send_word(w, 1'b0, none);
                end
            end
        end
    endtask

    // Result side: compare each accepted word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        decision_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            decisions_seen++;
            if (m_axis_tdata[19:18] < 2'd3)
                move_count[m_axis_tdata[19:18]]++;
            if (decisions_due.size() == 0)
            begin
                $error("decision word %0h arrived with nothing expected", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = decisions_due.pop_front();
                if (m_axis_tdata[1:0] !== want.new_lane)
                begin
                    $error("new_lane: expected %0d, actual %0d", want.new_lane,
                           m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[17:2] !== want.new_ref_speed)
                begin
                    $error("new_ref_speed: expected %0d, actual %0d", want.new_ref_speed,
                           m_axis_tdata[17:2]);
                    mismatches++;
                end
                if (m_axis_tdata[19:18] !== want.move)
                begin
                    $error("move: expected %0d, actual %0d", want.move, m_axis_tdata[19:18]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver readiness, with an occasional long hold so that the block backs up.
    initial
    begin : ready_drive
        int lo;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    rx_calm = !rx_calm;
                lo = rx_calm ? 0 : pick_gap();
                if (lo > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (lo) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        cfg_est.safe_gap = SAFE_GAP_RST;
        cfg_est.speed_limit = SPEED_LIMIT_RST;
        cfg_est.speed_step = SPEED_STEP_RST;
        cfg_est.last_lane = LAST_LANE_RST;
        ego_lane_est = '0;
        ego_pos_est = '0;
        clear_trackers_est();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values apply here: gap 480, limit 12672, step 57, rightmost lane 2.
        add_row(KIND_DECIDE, 0, 0, 0, 0, 1, 0, 57, MOVE_KEEP);
        add_row(KIND_DECIDE, 0, 0, 0, 65535, 1, 0, 12672, MOVE_KEEP);
        add_row(KIND_FRAME, 1, 1000, 0, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 1, 1100, 100, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 0, 800, 5000, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 2, 2000, 9000, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_DECIDE, 0, 0, 0, 10000, 1, 2, 10000, MOVE_RIGHT);
        add_row(KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 1, 1, 0, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 0, POS_MAX, 65535, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 2, 479, 65535, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 0, 100000, 12000, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_DECIDE, 3, POS_MAX, 65535, 30, 1, 0, 30, MOVE_LEFT);
        // Second decide without a new frame: now at the left edge, speed saturates at zero.
        add_row(KIND_DECIDE, 0, 0, 0, 30, 1, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 3, 5, 7, 0, 0, 0, 0, MOVE_KEEP);
        // Ego in lane 3, beyond the rightmost lane: a right change is never taken.
        add_row(KIND_FRAME, 3, 200000, 0, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 3, 200100, 300, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 2, 199000, 100, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 2, 201000, 20000, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_DECIDE, 0, 0, 0, 100, 1, 2, 100, MOVE_LEFT);
        // Equal costs on both sides: right wins.
        add_row(KIND_FRAME, 1, 5000, 0, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 1, 5010, 0, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 0, 6000, 8000, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_REPORT, 2, 7000, 8000, 0, 0, 0, 0, MOVE_KEEP);
        add_row(KIND_DECIDE, 0, 0, 0, 12672, 1, 2, 12672, MOVE_RIGHT);
        add_row(KIND_DECIDE, 0, 0, 0, 65535, 0, 0, 0, MOVE_KEEP);

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].fixed_exp, dir_rows[i].want);

        set_config(0, 1, 0, 0);
        run_traffic(133, 1'b0);
        set_config(65535, 65535, 4095, 3);
        run_traffic(133, 1'b0);

        // Back-pressure phase: the sender never pauses while the receiver holds off.
        set_config($urandom_range(16, 1500), $urandom_range(1, 65535), $urandom_range(0, 300),
                   $urandom_range(0, 3));
        tx_calm = 1'b1;
        hold_req = 1'b1;
        run_traffic(133, 1'b1);
        tx_calm = 1'b0;

        for (int ph = 0; ph < 3; ph++)
        begin
            set_config($urandom_range(0, 4000), $urandom_range(1, 65535),
                       $urandom_range(0, 4095), $urandom_range(0, 3));
            run_traffic(133, 1'b0);
        end
        set_config(SAFE_GAP_RST, SPEED_LIMIT_RST, SPEED_STEP_RST, LAST_LANE_RST);
        run_traffic(133, 1'b0);

        drain();
        $display("Sent %0d words over %0d register settings; checked %0d decisions.",
                 words_sent, settings_used, decisions_seen);
        $display("Moves seen: keep %0d, right %0d, left %0d; mismatches %0d.",
                 move_count[MOVE_KEEP], move_count[MOVE_RIGHT], move_count[MOVE_LEFT],
                 mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
